[rtl/tclb_pkg.sv]
package tclb_pkg;

	// default geometry of the row ring
	localparam int ROWS_DEF = 20;
	localparam int COLS_DEF = 40;

	// fixed field widths
	localparam int CHAR_W   = 8;
	localparam int LINE_W   = 5;
	localparam int COLSEL_W = 6;
	localparam int CROW_W   = 5;
	localparam int CCOL_W   = 6;

	// control characters
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [CHAR_W-1:0]   char_in;
		logic                end_of_text;
		logic [LINE_W-1:0]   line_sel;
		logic [COLSEL_W-1:0] col_sel;
	} cmd_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic              line_valid;
		logic [CROW_W-1:0] cursor_row;
		logic [CCOL_W-1:0] cursor_col;
		logic              ring_full;
	} res_t;

	// what the cursor side hands to the response stage with each item
	typedef struct packed {
		op_t                 op;
		logic                line_ok;
		logic                len_vld;
		logic [COLSEL_W-1:0] col;
		logic [CROW_W-1:0]   cursor_row;
		logic [CCOL_W-1:0]   cursor_col;
		logic                ring_full;
	} rd_info_t;

endpackage

[rtl/tclb_ram.sv]
module tclb_ram #(
	parameter int W = tclb_pkg::CHAR_W,
	parameter int D = tclb_pkg::ROWS_DEF,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/tclb_cursor.sv]
module tclb_cursor #(
	parameter int ROWS = tclb_pkg::ROWS_DEF,
	parameter int COLS = tclb_pkg::COLS_DEF,
	localparam int RW = $clog2(ROWS),
	localparam int CW = $clog2(COLS + 1),
	localparam int AW = $clog2(ROWS * COLS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  tclb_pkg::cmd_t     cmd,
	output logic               char_we,
	output logic [AW-1:0]      char_waddr,
	output logic [7:0]         char_wdata,
	output logic               len_we,
	output logic [RW-1:0]      len_waddr,
	output logic [CW-1:0]      len_wdata,
	output logic               rd_re,
	output logic [AW-1:0]      char_raddr,
	output logic [RW-1:0]      len_raddr,
	output tclb_pkg::rd_info_t info
);
	import tclb_pkg::*;

	localparam int SW = ((RW > LINE_W) ? RW : LINE_W) + 1;
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
	localparam logic [CW-1:0] COL_END  = CW'(COLS);

	logic [RW-1:0]   row_q, row_mid, row_d;
	logic [CW-1:0]   col_q, col_mid, col_d;
	logic            full_q, full_mid, full_d;
	logic            cr_pend_q, cr_pend_d;
	logic [ROWS-1:0] vld_q, vld_d;
	logic            brk_pend, brk_now, put_char, is_wr;
	logic [SW-1:0]   line_x, rot_x;
	logic [RW-1:0]   phys;
	logic            line_ok;

	assign is_wr = take && (cmd.op == OP_WRITE);

	// cursor update for a write item
	always_comb begin
		brk_pend = (col_q >= COL_END);
		row_mid  = row_q;
		full_mid = full_q;
		col_mid  = col_q;
		if (brk_pend) begin
			col_mid = '0;
			if (row_q == LAST_ROW) begin
				row_mid  = '0;
				full_mid = 1'b1;
			end else begin
				row_mid = row_q + 1'b1;
			end
		end
		row_d     = row_mid;
		full_d    = full_mid;
		col_d     = col_mid;
		brk_now   = 1'b0;
		put_char  = 1'b0;
		cr_pend_d = 1'b0;
		case (cmd.char_in) inside
			CH_NUL, CH_TAB, CH_VT: begin
			end
			CH_CR: begin
				col_d = COL_END;
				if (!cmd.end_of_text) begin
					cr_pend_d = 1'b1;
					brk_now   = 1'b1;
				end
			end
			CH_LF: begin
				if (!cr_pend_q) begin
					col_d   = COL_END;
					brk_now = 1'b1;
				end
			end
			default: begin
				put_char = 1'b1;
				col_d    = col_mid + 1'b1;
				if ((col_d == COL_END) && !cmd.end_of_text) begin
					brk_now = 1'b1;
				end
			end
		endcase
		if (brk_now) begin
			col_d = '0;
			if (row_mid == LAST_ROW) begin
				row_d  = '0;
				full_d = 1'b1;
			end else begin
				row_d = row_mid + 1'b1;
			end
		end
	end

	// row live bits: a cleared row reads as length zero
	always_comb begin
		vld_d = vld_q;
		if (brk_pend) begin
			vld_d[row_mid] = 1'b0;
		end
		if (put_char) begin
			vld_d[row_mid] = 1'b1;
		end
		if (brk_now) begin
			vld_d[row_d] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q     <= '0;
			col_q     <= '0;
			full_q    <= 1'b0;
			cr_pend_q <= 1'b0;
			vld_q     <= '0;
		end else if (is_wr) begin
			row_q     <= row_d;
			col_q     <= col_d;
			full_q    <= full_d;
			cr_pend_q <= cr_pend_d;
			vld_q     <= vld_d;
		end
	end

	assign char_we    = is_wr && put_char;
	assign char_waddr = AW'(int'(row_mid) * COLS + int'(col_mid));
	assign char_wdata = cmd.char_in;
	assign len_we     = is_wr && put_char;
	assign len_waddr  = row_mid;
	assign len_wdata  = col_mid + 1'b1;

	// display line to ring row
	always_comb begin
		line_x = SW'(cmd.line_sel);
		rot_x  = SW'(row_q) + SW'(1) + line_x;
		if (rot_x >= SW'(ROWS)) begin
			rot_x = rot_x - SW'(ROWS);
		end
		line_ok = full_q ? (line_x < SW'(ROWS)) : (line_x <= SW'(row_q));
		phys    = full_q ? RW'(rot_x) : RW'(cmd.line_sel);
	end

	assign rd_re      = take && (cmd.op == OP_READ);
	assign char_raddr = AW'(int'(phys) * COLS + int'(cmd.col_sel));
	assign len_raddr  = phys;

	always_comb begin
		info.op      = cmd.op;
		info.line_ok = line_ok;
		info.len_vld = line_ok && vld_q[phys];
		info.col     = cmd.col_sel;
		if (cmd.op == OP_WRITE) begin
			info.cursor_row = CROW_W'(row_d);
			info.cursor_col = CCOL_W'(col_d);
			info.ring_full  = full_d;
		end else begin
			info.cursor_row = CROW_W'(row_q);
			info.cursor_col = CCOL_W'(col_q);
			info.ring_full  = full_q;
		end
	end

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("ring full flag dropped");

	a_cr_at_col0: assert property (@(posedge clk) disable iff (!arst_n)
		cr_pend_q |-> (col_q == '0))
		else $error("cr memory set with cursor off column zero");

	a_row_live: assert property (@(posedge clk) disable iff (!arst_n)
		((col_q != '0) && (col_q != COL_END)) |-> vld_q[row_q])
		else $error("cursor row holds text but is marked empty");

	a_wrap_sets_full: assert property (@(posedge clk) disable iff (!arst_n)
		(is_wr && brk_now && (row_mid == LAST_ROW)) |=> (full_q && (row_q == '0)))
		else $error("rollover did not mark the ring full");

endmodule

[rtl/tclb_resp.sv]
module tclb_resp #(
	parameter int COLS = tclb_pkg::COLS_DEF,
	localparam int LW = $clog2(COLS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  tclb_pkg::rd_info_t info,
	input  logic [LW-1:0]      len_rd,
	input  logic [7:0]         char_rd,
	input  logic               res_stall,
	output logic               res_valid,
	output tclb_pkg::res_t     res,
	output logic               busy
);
	import tclb_pkg::*;

	localparam int MW = (LW > COLSEL_W) ? LW : COLSEL_W;

	logic     s1_vld_q;
	rd_info_t info_s1;
	logic     move, hit;
	res_t     res_d, res_q;
	logic     res_vld_q;

	assign move = s1_vld_q && (!res_vld_q || !res_stall);
	assign busy = s1_vld_q && !move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (take) begin
			s1_vld_q <= 1'b1;
		end else if (move) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			info_s1 <= info;
		end
	end

	// memory data lines up with the item in s1
	always_comb begin
		hit = info_s1.line_ok && info_s1.len_vld && (MW'(info_s1.col) < MW'(len_rd));
		res_d.cell_char  = (info_s1.op == OP_READ) ? (hit ? char_rd : CH_SPACE) : '0;
		res_d.line_valid = (info_s1.op == OP_READ) && info_s1.line_ok;
		res_d.cursor_row = info_s1.cursor_row;
		res_d.cursor_col = info_s1.cursor_col;
		res_d.ring_full  = info_s1.ring_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (move) begin
			res_vld_q <= 1'b1;
		end else if (!res_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_vld_q;
	assign res       = res_q;

endmodule

[rtl/text_console_line_buffer_unit.sv]
// text console line store: a ring of ROWS rows of COLS characters. a write item
// (op 0) feeds one character through the cursor logic (tab, vertical tab and nul
// ignored, cr or lf end the line, an lf straight after a mid-text cr dropped, a
// full row breaks when the next character arrives or at once inside a text); a
// read item (op 1) returns the byte at a display line (0 is the oldest) and
// column, with a space past the line end. every item gives exactly one result
// item carrying the cursor position and the ring-full flag after the item. one
// item is accepted per clock cycle while cmd_stall is low; the character and
// length memories are read at the accepting edge into the memory stage, and the
// output register loads from the memory stage once it is empty or its result is taken.
// characters live in a single-port-write memory of ROWS*COLS bytes, row lengths
// in a ROWS-deep memory; a row of live bits in flip-flops marks rows emptied by
// a line break, so no clearing pass is needed after reset. cmd_stall rises only
// while a result is held in both the memory stage and the output register.
module text_console_line_buffer_unit #(
	parameter int ROWS = tclb_pkg::ROWS_DEF,
	parameter int COLS = tclb_pkg::COLS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  tclb_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output tclb_pkg::res_t res
);
	import tclb_pkg::*;

	localparam int RW = $clog2(ROWS);
	localparam int CW = $clog2(COLS + 1);
	localparam int AW = $clog2(ROWS * COLS);

	// item handshake
	logic take;
	logic busy;

	// memory ports
	logic          char_we, len_we, rd_re;
	logic [AW-1:0] char_waddr, char_raddr;
	logic [7:0]    char_wdata, char_rd;
	logic [RW-1:0] len_waddr, len_raddr;
	logic [CW-1:0] len_wdata, len_rd;

	rd_info_t info;

	assign cmd_stall = busy;
	assign take      = cmd_valid && !cmd_stall;

	// cursor state, write decode and read address mapping
	tclb_cursor #(
		.ROWS(ROWS),
		.COLS(COLS)
	) u_cursor (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.cmd       (cmd),
		.char_we   (char_we),
		.char_waddr(char_waddr),
		.char_wdata(char_wdata),
		.len_we    (len_we),
		.len_waddr (len_waddr),
		.len_wdata (len_wdata),
		.rd_re     (rd_re),
		.char_raddr(char_raddr),
		.len_raddr (len_raddr),
		.info      (info)
	);

	// character store, one byte per cell, rows at a stride of COLS
	tclb_ram #(
		.W(CHAR_W),
		.D(ROWS * COLS)
	) u_char_ram (
		.clk  (clk),
		.we   (char_we),
		.waddr(char_waddr),
		.wdata(char_wdata),
		.re   (rd_re),
		.raddr(char_raddr),
		.rdata(char_rd)
	);

	// row lengths, valid only where the live bit of the row is set
	tclb_ram #(
		.W(CW),
		.D(ROWS)
	) u_len_ram (
		.clk  (clk),
		.we   (len_we),
		.waddr(len_waddr),
		.wdata(len_wdata),
		.re   (rd_re),
		.raddr(len_raddr),
		.rdata(len_rd)
	);

	// memory stage and output register
	tclb_resp #(
		.COLS(COLS)
	) u_resp (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.info     (info),
		.len_rd   (len_rd),
		.char_rd  (char_rd),
		.res_stall(res_stall),
		.res_valid(res_valid),
		.res      (res),
		.busy     (busy)
	);

endmodule

[tb/console_cell_checker.sv]
`timescale 1ns / 1ps

module console_cell_checker
	import tclb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  logic cmd_stall,
	input  cmd_t cmd,
	input  logic res_valid,
	input  logic res_stall,
	input  res_t res,
	output int   fail_count,
	output int   pending_count
);

	localparam int ROWS = ROWS_DEF;
	localparam int COLS = COLS_DEF;

	// own copy of the console state
	logic [CHAR_W-1:0]   glyph_mem [ROWS*COLS];
	logic [CCOL_W-1:0]   row_len [ROWS];
	int unsigned         cur_row;
	int unsigned         cur_col;
	logic                ring_wrapped;
	logic                after_cr;

	res_t due_results [$];

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < 100)
			$display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
		fail_count++;
	endtask

	function automatic void advance_row();
		cur_col = 0;
		cur_row++;
		if (cur_row >= ROWS) begin
			cur_row = 0;
			ring_wrapped = 1'b1;
		end
		row_len[cur_row] = '0;
	endfunction

	function automatic void put_char(logic [CHAR_W-1:0] ch, logic eot);
		logic was_cr;
		was_cr = after_cr;
		// a pending break is taken by any write, even an ignored one
		if (cur_col >= COLS)
			advance_row();
		after_cr = 1'b0;
		case (ch)
			CH_NUL, CH_TAB, CH_VT: ;
			CH_CR: begin
				cur_col = COLS;
				if (!eot) begin
					after_cr = 1'b1;
					advance_row();
				end
			end
			CH_LF: begin
				if (!was_cr) begin
					cur_col = COLS;
					advance_row();
				end
			end
			default: begin
				glyph_mem[cur_row*COLS + cur_col] = ch;
				cur_col++;
				row_len[cur_row] = CCOL_W'(cur_col);
				if (cur_col >= COLS && !eot)
					advance_row();
			end
		endcase
	endfunction

	function automatic res_t console_step(cmd_t c);
		res_t        r;
		int unsigned shown;
		int unsigned phys;
		r = '0;
		if (c.op == OP_WRITE) begin
			put_char(c.char_in, c.end_of_text);
		end else begin
			shown = ring_wrapped ? ROWS : cur_row + 1;
			r.cell_char = CH_SPACE;
			if (c.line_sel < shown) begin
				phys = ring_wrapped ? (cur_row + 1 + c.line_sel) % ROWS : c.line_sel;
				r.line_valid = 1'b1;
				if (c.col_sel < row_len[phys] && c.col_sel < COLS)
					r.cell_char = glyph_mem[phys*COLS + c.col_sel];
			end
		end
		r.cursor_row = CROW_W'(cur_row);
		r.cursor_col = CCOL_W'(cur_col);
		r.ring_full  = ring_wrapped;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			for (int i = 0; i < ROWS*COLS; i++)
				glyph_mem[i] = '0;
			for (int i = 0; i < ROWS; i++)
				row_len[i] = '0;
			cur_row = 0;
			cur_col = 0;
			ring_wrapped = 1'b0;
			after_cr = 1'b0;
			due_results.delete();
			pending_count = 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				due_results.push_back(console_step(cmd));
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					report_mismatch("result with nothing due, cell_char",
						int'(res.cell_char), 0);
				end else begin
					want = due_results.pop_front();
					if (res.cell_char !== want.cell_char)
						report_mismatch("cell_char", int'(res.cell_char),
							int'(want.cell_char));
					if (res.line_valid !== want.line_valid)
						report_mismatch("line_valid", int'(res.line_valid),
							int'(want.line_valid));
					if (res.cursor_row !== want.cursor_row)
						report_mismatch("cursor_row", int'(res.cursor_row),
							int'(want.cursor_row));
					if (res.cursor_col !== want.cursor_col)
						report_mismatch("cursor_col", int'(res.cursor_col),
							int'(want.cursor_col));
					if (res.ring_full !== want.ring_full)
						report_mismatch("ring_full", int'(res.ring_full),
							int'(want.ring_full));
				end
			end
			pending_count = due_results.size();
		end
	end

endmodule

[tb/text_console_line_buffer_unit_tb.sv]
`timescale 1ns / 1ps

module text_console_line_buffer_unit_tb;

	import tclb_pkg::*;

	// quiet cycles with nothing accepted on either side before giving up
	localparam int STALL_LIMIT = 1000;
	// length of the long receiver hold-off
	localparam int HOLD_CYCLES = 120;
	// random items wanted, ignored characters not counted
	localparam int RANDOM_ITEMS = 850;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	int fail_count;
	int pending_count;

	// stimulus-side controls shared with the receiver
	logic steady = 1'b0;
	int   hold_reqs = 0;
	int   items_done = 0;
	int   quiet_run = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_console_line_buffer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	console_cell_checker CHECK (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd           (cmd),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res           (res),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// offer one item, with the odd random gap before it, and hold it until taken
	task automatic send_item(input cmd_t c);
		while (!steady && $urandom_range(0, 99) < 9) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		// characters that the block just skips do not count as work done
		if (!(c.op == OP_WRITE && (c.char_in inside {CH_NUL, CH_TAB, CH_VT})))
			items_done++;
	endtask

	// write item; the read fields carry junk that the block must not look at
	task automatic put(input logic [CHAR_W-1:0] ch, input logic eot);
		cmd_t c;
		c.op          = OP_WRITE;
		c.char_in     = ch;
		c.end_of_text = eot;
		c.line_sel    = LINE_W'($urandom_range(0, 19));
		c.col_sel     = COLSEL_W'($urandom_range(0, 39));
		send_item(c);
	endtask

	// read item; the character fields carry junk
	task automatic peek(input int line, input int col);
		cmd_t c;
		c.op          = OP_READ;
		c.char_in     = CHAR_W'($urandom_range(0, 255));
		c.end_of_text = 1'($urandom_range(0, 1));
		c.line_sel    = LINE_W'(line);
		c.col_sel     = COLSEL_W'(col);
		send_item(c);
	endtask

	// text byte, mostly printable ascii, now and then any byte from space up to 8'hFF
	function automatic logic [CHAR_W-1:0] text_byte();
		if ($urandom_range(0, 3) == 0)
			return CHAR_W'($urandom_range(8'h20, 8'hFF));
		return CHAR_W'($urandom_range(8'h21, 8'h7E));
	endfunction

	// receiver: random stalls, a calm stretch, and one long hold-off on request
	initial begin
		int seen;
		int hold_left;
		seen = 0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else if (hold_reqs != seen) begin
				seen = hold_reqs;
				hold_left = HOLD_CYCLES - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= !steady && ($urandom_range(0, 99) < 9);
			end
		end
	end

	// watchdog: nothing moving on either channel for too long means a hang
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_run <= 0;
		else
			quiet_run <= quiet_run + 1;
		if (quiet_run >= STALL_LIMIT) begin
			$display("text_console_line_buffer_unit verification failed");
			$finish;
		end
	end

	initial begin
		int  kind;
		int  len;
		bit  hold_fired;
		hold_fired = 1'b0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		// empty console: line 0 shown but blank, the last line not shown at all
		peek(0, 0);
		peek(19, 39);
		// extremes of the character byte, then the skipped controls
		put(8'h41, 1'b0);
		put(8'hFF, 1'b0);
		put(8'h01, 1'b0);
		put(8'h80, 1'b0);
		put(CH_NUL, 1'b0);
		put(CH_TAB, 1'b1);
		put(CH_VT, 1'b0);
		peek(0, 3);
		peek(0, 4);
		// cr inside a text breaks at once and swallows the lf behind it
		put(CH_CR, 1'b0);
		put(CH_LF, 1'b0);
		put(8'h78, 1'b1);
		// cr at the end of a text leaves the break pending for the next write
		put(CH_CR, 1'b1);
		put(8'h79, 1'b0);
		// a lone lf and an lf ending a text both break at once
		put(CH_LF, 1'b0);
		put(CH_LF, 1'b1);
		put(8'h7E, 1'b0);
		// cr at the end of a text, then lf: the lf is not swallowed
		put(CH_CR, 1'b1);
		put(CH_LF, 1'b0);
		peek(1, 0);
		peek(2, 0);
		peek(16, 32);
		peek(3, 63 & 39);
		peek(4, 0);

		// random part
		items_done = 0;
		while (items_done < RANDOM_ITEMS) begin
			if (!hold_fired && items_done >= 200) begin
				// stall the receiver for a long time while the sender keeps going
				hold_fired = 1'b1;
				hold_reqs <= hold_reqs + 1;
			end else begin
				steady <= (items_done >= 400 && items_done < 550);
			end
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				// a short string, ended by the text end alone or by one of the usual line endings
				len = $urandom_range(1, 12);
				for (int i = 0; i < len - 1; i++)
					put(text_byte(), 1'b0);
				case ($urandom_range(0, 4))
					0: put(text_byte(), 1'b1);
					1: begin
						put(text_byte(), 1'b0);
						put(CH_CR, 1'b0);
						put(CH_LF, 1'b1);
					end
					2: begin
						put(text_byte(), 1'b0);
						put(CH_LF, 1'b1);
					end
					3: begin
						put(text_byte(), 1'b0);
						put(CH_CR, 1'b1);
					end
					default: begin
						put(text_byte(), 1'b0);
						put(CH_CR, 1'($urandom_range(0, 1)));
						put(CH_LF, 1'($urandom_range(0, 1)));
					end
				endcase
			end else if (kind < 50) begin
				// long line around the row width, often exactly one row
				len = ($urandom_range(0, 2) == 0) ? COLS_DEF : $urandom_range(35, 50);
				for (int i = 0; i < len - 1; i++)
					put(text_byte(), 1'b0);
				put(text_byte(), 1'($urandom_range(0, 1)));
			end else if (kind < 85) begin
				// a burst of reads, half of them near the start of a line
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					peek($urandom_range(0, 19),
						$urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(0, 39));
			end else if (kind < 95) begin
				// noise: any byte, any flag, either operation
				if ($urandom_range(0, 1))
					put(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				else
					peek($urandom_range(0, 19), $urandom_range(0, 39));
			end else begin
				// bare control characters
				case ($urandom_range(0, 4))
					0: put(CH_NUL, 1'($urandom_range(0, 1)));
					1: put(CH_TAB, 1'($urandom_range(0, 1)));
					2: put(CH_VT, 1'($urandom_range(0, 1)));
					3: put(CH_CR, 1'($urandom_range(0, 1)));
					default: put(CH_LF, 1'($urandom_range(0, 1)));
				endcase
			end
		end
		cmd_valid <= 1'b0;
		steady <= 1'b0;

		// drain, then a few cycles for anything stray to show up
		while (pending_count != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		if (fail_count == 0 && pending_count == 0)
			$display("text_console_line_buffer_unit verification clean");
		else
			$display("text_console_line_buffer_unit verification failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/tclb_pkg.sv
rtl/tclb_ram.sv
rtl/tclb_cursor.sv
rtl/tclb_resp.sv
rtl/text_console_line_buffer_unit.sv
tb/console_cell_checker.sv
tb/text_console_line_buffer_unit_tb.sv
